@@ hdl/ego_pkg.sv @@
// Shared types, constants and helper functions of the odometry block.
package ego_pkg;

    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam int ITER_W           = 5;

    localparam int MA = 33;
    localparam int MB = 26;
    localparam int MP = MA + MB;
    localparam int CW = 44;
    localparam int ZW = 22;
    localparam int AW = 48;
    localparam int RW = 21;

    localparam logic signed [ZW-1:0] ANG_PI      = 22'sd411775;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 22'sd205887;
    localparam logic signed [MB-1:0] YAW_TO_RAD  = 26'sd1499226;
    localparam logic signed [MB-1:0] CORDIC_GAIN = 26'sd636751;
    localparam logic signed [15:0]   YAW_MAX     = 16'sd18000;
    localparam logic signed [15:0]   YAW_MIN     = -16'sd18000;

    localparam logic [1:0] REG_X_SCALE       = 2'd0;
    localparam logic [1:0] REG_Y_SCALE       = 2'd1;
    localparam logic [1:0] REG_TURN_SCALE    = 2'd2;
    localparam logic [1:0] REG_CENTER_OFFSET = 2'd3;

    localparam logic [1:0] CH_X    = 2'd0;
    localparam logic [1:0] CH_Y    = 2'd1;
    localparam logic [1:0] CH_TURN = 2'd2;

    typedef enum logic [1:0] {
        FUNC_EDGE    = 2'd0,
        FUNC_REFRESH = 2'd1,
        FUNC_CLEAR   = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_YAW,
        OP_XMUL,
        OP_YMUL,
        OP_PMUL,
        OP_OMUL,
        OP_PREP,
        OP_CORD,
        OP_G0,
        OP_G1,
        OP_G2,
        OP_G3,
        OP_ACC,
        OP_OUT
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YAW,
        ST_XMUL,
        ST_YMUL,
        ST_PMUL,
        ST_OMUL,
        ST_PREP,
        ST_CORD,
        ST_G0,
        ST_G1,
        ST_G2,
        ST_G3,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic in_take;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic refresh;
        logic cord_last;
        logic out_full;
    } status_t;

    function automatic logic [17:0] atan_q17(input logic [ITER_W-1:0] i);
        logic [17:0] v;
        case (i)
            5'd0:    v = 18'd102944;
            5'd1:    v = 18'd60771;
            5'd2:    v = 18'd32110;
            5'd3:    v = 18'd16299;
            5'd4:    v = 18'd8181;
            5'd5:    v = 18'd4095;
            5'd6:    v = 18'd2048;
            5'd7:    v = 18'd1024;
            5'd8:    v = 18'd512;
            5'd9:    v = 18'd256;
            5'd10:   v = 18'd128;
            5'd11:   v = 18'd64;
            5'd12:   v = 18'd32;
            5'd13:   v = 18'd16;
            5'd14:   v = 18'd8;
            5'd15:   v = 18'd4;
            5'd16:   v = 18'd2;
            5'd17:   v = 18'd1;
            default: v = 18'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [CW-1:0] sat_delta(input logic signed [59:0] v);
        logic signed [59:0] lim;
        logic signed [CW-1:0] r;
        lim = 60'sd549755813887;
        if (v > lim)
            r = CW'(lim);
        else if (v < -lim)
            r = CW'(-lim);
        else
            r = CW'(v);
        return r;
    endfunction

    function automatic logic signed [AW-1:0] sat_accum(input logic signed [AW:0] v);
        logic signed [AW-1:0] r;
        if (v > $signed({2'b00, {(AW-1){1'b1}}}))
            r = {1'b0, {(AW-1){1'b1}}};
        else if (v < $signed({2'b11, {(AW-1){1'b0}}}))
            r = {1'b1, {(AW-1){1'b0}}};
        else
            r = v[AW-1:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat_pos(input logic signed [AW-1:0] acc);
        logic signed [AW-13:0] s;
        logic signed [31:0] r;
        s = acc[AW-1:12];
        if (s > $signed(36'sd2147483647))
            r = 32'sh7fffffff;
        else if (s < -$signed(36'sd2147483648))
            r = 32'sh80000000;
        else
            r = s[31:0];
        return r;
    endfunction

endpackage

@@ hdl/ego_ctrl.sv @@
// Sequencing state machine of the odometry block.
module ego_ctrl
    import ego_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && status.refresh)
                    state_next = ST_YAW;
            end
            ST_YAW:  state_next = ST_XMUL;
            ST_XMUL: state_next = ST_YMUL;
            ST_YMUL: state_next = ST_PMUL;
            ST_PMUL: state_next = ST_OMUL;
            ST_OMUL: state_next = ST_PREP;
            ST_PREP: state_next = ST_CORD;
            ST_CORD:
            begin
                if (status.cord_last)
                    state_next = ST_G0;
            end
            ST_G0:   state_next = ST_G1;
            ST_G1:   state_next = ST_G2;
            ST_G2:   state_next = ST_G3;
            ST_G3:   state_next = ST_ACC;
            ST_ACC:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (!status.out_full)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        cmd.in_take = 1'b0;
        cmd.op      = OP_IDLE;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.in_take = s_tvalid;
            end
            ST_YAW:  cmd.op = OP_YAW;
            ST_XMUL: cmd.op = OP_XMUL;
            ST_YMUL: cmd.op = OP_YMUL;
            ST_PMUL: cmd.op = OP_PMUL;
            ST_OMUL: cmd.op = OP_OMUL;
            ST_PREP: cmd.op = OP_PREP;
            ST_CORD: cmd.op = OP_CORD;
            ST_G0:   cmd.op = OP_G0;
            ST_G1:   cmd.op = OP_G1;
            ST_G2:   cmd.op = OP_G2;
            ST_G3:   cmd.op = OP_G3;
            ST_ACC:  cmd.op = OP_ACC;
            ST_OUT:  cmd.op = OP_OUT;
            default: cmd.op = OP_IDLE;
        endcase
    end

endmodule

@@ hdl/ego_datapath.sv @@
// Counters, shared multiplier, CORDIC rotator and accumulators of the odometry block.
module ego_datapath
    import ego_pkg::*;
#(
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [23:0] x_scale,
    input  logic [23:0] y_scale,
    input  logic [23:0] turn_scale,
    input  logic [23:0] center_offset,
    input  logic [23:0] in_data,
    input  logic [3:0]  in_user,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata
);

    localparam int NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam logic signed [COUNT_WIDTH-1:0] CMAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CMIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    func_t                    func;
    logic [1:0]               ch;
    logic                     b_lvl;
    logic signed [15:0]       yaw_in;
    logic signed [15:0]       yaw_c;

    logic signed [COUNT_WIDTH-1:0] cnt_reg [3];
    logic signed [COUNT_WIDTH-1:0] cnt_next [3];
    logic signed [15:0]       yaw_reg;
    logic signed [MP-1:0]     prod_reg;
    logic signed [MP-1:0]     p0_reg;
    logic signed [MA-1:0]     ma;
    logic signed [MB-1:0]     mb;
    logic signed [RW-1:0]     rad_reg;
    logic signed [RW-1:0]     last_reg;
    logic signed [ZW-1:0]     dp2_reg;
    logic signed [MP-1:0]     dx_reg;
    logic signed [MP-1:0]     dy_reg;
    logic signed [MP-1:0]     dp_reg;
    logic signed [CW-1:0]     a_reg;
    logic signed [CW-1:0]     b_reg;
    logic signed [ZW-1:0]     z_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic signed [CW-1:0]     wy_reg;
    logic signed [AW-1:0]     xacc_reg;
    logic signed [AW-1:0]     yacc_reg;
    logic                     out_valid_reg;
    logic [79:0]              out_reg;

    logic signed [MP-1:0]     rad_sum;
    logic signed [ZW-1:0]     d0;
    logic signed [ZW-1:0]     d1;
    logic signed [ZW-1:0]     d2;
    logic signed [MP-1:0]     off;
    logic signed [CW-1:0]     dx2;
    logic signed [CW-1:0]     dy2;
    logic signed [59:0]       dyd;
    logic signed [ZW-1:0]     rad_z;
    logic signed [CW-1:0]     sa;
    logic signed [CW-1:0]     sb;
    logic signed [ZW-1:0]     atan_v;
    logic signed [65:0]       gsum;
    logic signed [CW-1:0]     gres;

    assign func   = func_t'(in_user[1:0]);
    assign ch     = in_user[3:2];
    assign b_lvl  = in_data[0];
    assign yaw_in = $signed(in_data[16:1]);
    assign yaw_c  = (yaw_in > YAW_MAX) ? YAW_MAX : ((yaw_in < YAW_MIN) ? YAW_MIN : yaw_in);

    assign status.refresh   = (func == FUNC_REFRESH);
    assign status.cord_last = (iter_reg == ITER_W'(NSTEPS - 1));
    assign status.out_full  = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cnt_next[k] = cnt_reg[k];
        end
        if (cmd.in_take && func == FUNC_EDGE && ch != 2'd3)
        begin
            if ((ch == CH_X) ? !b_lvl : b_lvl)
            begin
                if (cnt_reg[ch] != CMAX)
                    cnt_next[ch] = cnt_reg[ch] + COUNT_WIDTH'(1);
            end
            else
            begin
                if (cnt_reg[ch] != CMIN)
                    cnt_next[ch] = cnt_reg[ch] - COUNT_WIDTH'(1);
            end
        end
        if ((cmd.in_take && func == FUNC_CLEAR) || cmd.op == OP_OMUL)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cnt_next[k] = '0;
            end
        end
    end

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            OP_YAW:
            begin
                ma = MA'(yaw_reg);
                mb = YAW_TO_RAD;
            end
            OP_XMUL:
            begin
                ma = MA'(cnt_reg[CH_X]);
                mb = $signed({2'b00, x_scale});
            end
            OP_YMUL:
            begin
                ma = MA'(cnt_reg[CH_Y]);
                mb = $signed({2'b00, y_scale});
            end
            OP_PMUL:
            begin
                ma = MA'(cnt_reg[CH_TURN]);
                mb = $signed({2'b00, turn_scale});
            end
            OP_OMUL:
            begin
                ma = MA'(dp2_reg);
                mb = $signed({2'b00, center_offset});
            end
            OP_G0:
            begin
                ma = $signed({11'b0, a_reg[21:0]});
                mb = CORDIC_GAIN;
            end
            OP_G1:
            begin
                ma = MA'($signed(a_reg[CW-1:22]));
                mb = CORDIC_GAIN;
            end
            OP_G2:
            begin
                ma = $signed({11'b0, b_reg[21:0]});
                mb = CORDIC_GAIN;
            end
            OP_G3:
            begin
                ma = MA'($signed(b_reg[CW-1:22]));
                mb = CORDIC_GAIN;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_comb
    begin
        rad_sum = prod_reg + MP'(32768);
        d0      = ZW'(rad_reg) - ZW'(last_reg);
        d1      = (d0 > ANG_HALF_PI) ? d0 - ANG_PI : d0;
        d2      = (d1 < -ANG_HALF_PI) ? d1 + ANG_PI : d1;
        off     = (prod_reg + MP'(65536)) >>> 17;
        dx2     = sat_delta(60'(dx_reg) - 60'(off));
        dyd     = (60'(dy_reg) - 60'(dp_reg)) >>> 1;
        dy2     = sat_delta(dyd);
        rad_z   = ZW'(rad_reg);
        sa      = a_reg >>> iter_reg;
        sb      = b_reg >>> iter_reg;
        atan_v  = $signed({4'b0, atan_q17(iter_reg)});
        gsum    = (66'(prod_reg) <<< 22) + 66'(p0_reg) + 66'sd524288;
        gres    = gsum[CW+19:20];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        if (cmd.in_take && func == FUNC_REFRESH)
            yaw_reg <= yaw_c;
        case (cmd.op)
            OP_XMUL: rad_reg <= rad_sum[RW+15:16];
            OP_YMUL:
            begin
                dx_reg  <= prod_reg;
                dp2_reg <= d2;
            end
            OP_PMUL: dy_reg <= prod_reg;
            OP_OMUL: dp_reg <= prod_reg;
            OP_PREP:
            begin
                iter_reg <= '0;
                if (rad_z > ANG_HALF_PI)
                begin
                    a_reg <= -dx2;
                    b_reg <= dy2;
                    z_reg <= rad_z - ANG_HALF_PI;
                end
                else if (rad_z < -ANG_HALF_PI)
                begin
                    a_reg <= dx2;
                    b_reg <= -dy2;
                    z_reg <= rad_z + ANG_HALF_PI;
                end
                else
                begin
                    a_reg <= dy2;
                    b_reg <= dx2;
                    z_reg <= rad_z;
                end
            end
            OP_CORD:
            begin
                iter_reg <= iter_reg + 1'b1;
                if (z_reg >= 0)
                begin
                    a_reg <= a_reg - sb;
                    b_reg <= b_reg + sa;
                    z_reg <= z_reg - atan_v;
                end
                else
                begin
                    a_reg <= a_reg + sb;
                    b_reg <= b_reg - sa;
                    z_reg <= z_reg + atan_v;
                end
            end
            OP_G1: p0_reg <= prod_reg;
            OP_G2: wy_reg <= gres;
            OP_G3: p0_reg <= prod_reg;
            OP_OUT:
            begin
                if (!status.out_full)
                    out_reg <= {yaw_reg, sat_pos(yacc_reg), sat_pos(xacc_reg)};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cnt_reg[k] <= '0;
            end
            last_reg      <= '0;
            xacc_reg      <= '0;
            yacc_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                cnt_reg[k] <= cnt_next[k];
            end
            if (cmd.op == OP_YMUL)
                last_reg <= rad_reg;
            if (cmd.in_take && func == FUNC_CLEAR)
            begin
                xacc_reg <= '0;
                yacc_reg <= '0;
            end
            else if (cmd.op == OP_ACC)
            begin
                xacc_reg <= sat_accum((AW+1)'(xacc_reg) + (AW+1)'(gres));
                yacc_reg <= sat_accum((AW+1)'(yacc_reg) + (AW+1)'(wy_reg));
            end
            if (cmd.op == OP_OUT && !status.out_full)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

@@ hdl/encoder_gyro_odometry.sv @@
// Top level of the encoder and gyro odometry block with its register port.
//
// Input items arrive on the s_t* stream. tuser carries the item kind (edge,
// refresh or clear) and the encoder channel; tdata carries the B level and
// the gyro yaw. An edge or clear transfer gives no result. After a refresh
// transfer the block runs a sequence through one shared 33 x 26 multiplier
// and an iterative CORDIC rotator, one step per cycle. No new item is taken
// until the sequence is done and the block is idle again. Each refresh
// produces one result transfer on the m_t* stream with position and
// heading. The result sits in an output register, so further edges are
// taken while it waits; a stalled receiver only holds the next refresh at
// its last step. Reset clears counters, pose and the previous heading
// angle and loads the register defaults; the reported heading is not
// reset. Registers are written through the APB port; the user must write
// them only while idle, which the block itself does not enforce.
module encoder_gyro_odometry
    import ego_pkg::*;
#(
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // b_level, yaw_centideg[16:1], zero pad
    input  logic [3:0]  s_tuser,  // func[1:0], channel[3:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata   // x_pos[31:0], y_pos[63:32], heading_centideg[79:64]
);

    logic [23:0] x_scale_reg;
    logic [23:0] y_scale_reg;
    logic [23:0] turn_scale_reg;
    logic [23:0] center_offset_reg;
    logic [23:0] rd_val;
    logic        wr_en;
    cmd_t        cmd;
    status_t     status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_reg       <= 24'd65536;
            y_scale_reg       <= 24'd65536;
            turn_scale_reg    <= 24'd65536;
            center_offset_reg <= 24'd0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_X_SCALE:       x_scale_reg       <= pwdata[23:0];
                REG_Y_SCALE:       y_scale_reg       <= pwdata[23:0];
                REG_TURN_SCALE:    turn_scale_reg    <= pwdata[23:0];
                REG_CENTER_OFFSET: center_offset_reg <= pwdata[23:0];
                default:           x_scale_reg       <= x_scale_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_X_SCALE:       rd_val = x_scale_reg;
            REG_Y_SCALE:       rd_val = y_scale_reg;
            REG_TURN_SCALE:    rd_val = turn_scale_reg;
            REG_CENTER_OFFSET: rd_val = center_offset_reg;
            default:           rd_val = '0;
        endcase
    end

    assign prdata = {8'b0, rd_val};

    ego_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ego_datapath #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .x_scale       (x_scale_reg),
        .y_scale       (y_scale_reg),
        .turn_scale    (turn_scale_reg),
        .center_offset (center_offset_reg),
        .in_data       (s_tdata),
        .in_user       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule
